>>> rtl/esp_pkg.sv
// Shared types and constants of the Euclidean shortest path unit.
// Used by the controller, the datapath, the square root unit and the top level.
`timescale 1ns / 1ps

package esp_pkg;

  localparam int MAX_NODES      = 1024;
  localparam int NODE_AW        = $clog2(MAX_NODES);
  localparam int MAX_EDGE_SLOTS = 8192;
  localparam int EDGE_AW        = $clog2(MAX_EDGE_SLOTS);
  localparam int EDGE_TOT_W     = EDGE_AW + 1;
  localparam int IDX_W          = 11;
  localparam int COORD_W        = 16;
  localparam int FRACTION_BITS  = 16;
  localparam int DIST_W         = 48;
  localparam int SQ_IN_W        = 2 * COORD_W + 2;
  localparam int ROOT_W         = SQ_IN_W / 2 + FRACTION_BITS;
  localparam int REM_W          = ROOT_W + 3;
  localparam int QCNT_W         = NODE_AW + 1;
  localparam int START_INT      = 114514;

  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(START_INT) << FRACTION_BITS;
  localparam logic [DIST_W-1:0] DIST_MAX   = '1;

  typedef enum logic [1:0] {
    OP_LOAD_NODE = 2'd0,
    OP_ADD_EDGE  = 2'd1,
    OP_SOLVE     = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_E_CHK, S_E_RDA, S_E_RDB, S_E_DIF, S_E_SQX, S_E_SQY, S_E_RT0, S_E_ROOT,
    S_E_HA, S_E_HB, S_E_HL, S_E_LK1, S_E_LK2,
    S_S_INIT, S_S_SEED, S_S_POP, S_S_U, S_S_UD, S_S_HD, S_S_EDGE, S_S_ED,
    S_S_CMP, S_S_TGT, S_S_TD,
    S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    STEP_NOP, STEP_CAPTURE, STEP_CLEAR,
    STEP_E_CHK, STEP_E_RDA, STEP_E_RDB, STEP_E_DIF, STEP_E_SQX, STEP_E_SQY,
    STEP_E_ROOT_GO, STEP_E_HA, STEP_E_HB, STEP_E_HL, STEP_E_LK1, STEP_E_LK2,
    STEP_S_INIT, STEP_S_SEED, STEP_S_POP, STEP_S_U, STEP_S_UD, STEP_S_HD,
    STEP_S_EDGE, STEP_S_ED, STEP_S_CMP, STEP_S_TGT, STEP_S_TD,
    STEP_EMIT
  } dp_step_t;

  typedef struct packed {
    dp_step_t step;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic ep_ok;
    logic edge_full;
    logic src_ok;
    logic clr_last;
    logic root_done;
    logic edge_nil;
    logic q_empty;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } coord_t;

  typedef struct packed {
    logic [NODE_AW-1:0] tgt;
    logic [ROOT_W-1:0]  wt;
    logic [EDGE_AW-1:0] nxt;
  } edge_t;

  typedef struct packed {
    logic              mark;
    logic [DIST_W-1:0] cost;
  } node_t;

endpackage

>>> rtl/esp_sqrt.sv
// Iterative digit-by-digit square root, one root bit per cycle, fixed point result.
// Depends on esp_pkg for widths.
`timescale 1ns / 1ps

module esp_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [esp_pkg::SQ_IN_W-1:0]    radicand,
  output logic                           busy,
  output logic                           done,
  output logic [esp_pkg::ROOT_W-1:0]     root
);
  import esp_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SQ_IN_W-1:0]  m_r, m_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;

  // Bring down the next digit pair and try the next root bit
  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], m_r[SQ_IN_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    m_nxt    = m_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ROOT_W);
      m_nxt    = radicand;
      root_nxt = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      m_nxt   = {m_r[SQ_IN_W-3:0], 2'b00};
      cnt_nxt = cnt_r - 1'b1;
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    m_r    <= m_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

>>> rtl/esp_dp.sv
// Datapath: node, edge, list head, distance and queue memories, edge length
// arithmetic and result register. Depends on esp_pkg and esp_sqrt.
`timescale 1ns / 1ps

module esp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  esp_pkg::cmd_t                 cmd,
  output esp_pkg::status_t              status,
  input  logic                          in_valid,
  input  logic [1:0]                    in_operation,
  input  logic [esp_pkg::IDX_W-1:0]     in_node_index,
  input  logic signed [esp_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [esp_pkg::COORD_W-1:0] in_coord_y,
  input  logic [esp_pkg::IDX_W-1:0]     in_edge_from,
  input  logic [esp_pkg::IDX_W-1:0]     in_edge_to,
  input  logic [esp_pkg::IDX_W-1:0]     in_source_node,
  input  logic [esp_pkg::IDX_W-1:0]     in_target_node,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [esp_pkg::DIST_W-1:0]    out_distance,
  output logic                          out_reached,
  output logic                          out_edge_overflow,
  input  logic                          cfg_wr_en,
  input  logic [esp_pkg::IDX_W-1:0]     cfg_wr_data
);
  import esp_pkg::*;

  function automatic logic [NODE_AW-1:0] node_addr(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] d;
    d = v - IDX_W'(1);
    return d[NODE_AW-1:0];
  endfunction

  // Memories
  coord_t             coord_mem [MAX_NODES];
  logic [EDGE_AW-1:0] head_mem  [MAX_NODES];
  edge_t              edge_mem  [MAX_EDGE_SLOTS];
  node_t              node_mem  [MAX_NODES];
  logic [NODE_AW-1:0] queue_mem [MAX_NODES];

  coord_t             coord_q;
  logic [EDGE_AW-1:0] head_q;
  edge_t              edge_q;
  node_t              node_q;
  logic [NODE_AW-1:0] queue_q;

  logic               coord_we, head_we, edge_we, node_we, queue_we;
  logic [NODE_AW-1:0] coord_wa, coord_ra, head_wa, head_ra, node_wa, node_ra;
  logic [NODE_AW-1:0] queue_wa, queue_ra, queue_wd;
  logic [EDGE_AW-1:0] edge_wa, edge_ra, head_wd;
  coord_t             coord_wd;
  edge_t              edge_wd;
  node_t              node_wd;

  // Registers
  logic [IDX_W-1:0]      node_count_r;
  op_t                   op_r;
  logic [IDX_W-1:0]      a_r, b_r, s_r, t_r;
  coord_t                ca_r;
  logic [COORD_W-1:0]    ux_r, uy_r;
  logic [2*COORD_W-1:0]  sqx_r, sqy_r;
  logic [EDGE_AW-1:0]    ha_r, hb_r;
  logic [EDGE_TOT_W-1:0] edge_total_r;
  logic [NODE_AW-1:0]    clr_cnt_r;
  logic [NODE_AW-1:0]    u_r, v_r, qh_r;
  logic [QCNT_W-1:0]     qc_r;
  logic [DIST_W-1:0]     du_r;
  logic [EDGE_AW-1:0]    e_r, nx_r;
  logic [ROOT_W-1:0]     w_r;
  logic [DIST_W-1:0]     res_dist_r;
  logic                  res_reached_r, res_ovf_r;
  logic                  out_valid_r;
  logic [DIST_W-1:0]     out_dist_r;
  logic                  out_reached_r, out_ovf_r;

  // Derived values
  logic [IDX_W-1:0]      n_use;
  logic                  capture, load_ok;
  logic [COORD_W:0]      dx, dy;
  logic [EDGE_AW-1:0]    slot1, slot2;
  logic [DIST_W:0]       sum_w;
  logic [DIST_W-1:0]     sum;
  logic                  relax, push, out_free, out_load;
  logic                  root_busy, root_done;
  logic [ROOT_W-1:0]     root;

  assign n_use = (node_count_r == '0) ? IDX_W'(1) :
                 (node_count_r > IDX_W'(MAX_NODES)) ? IDX_W'(MAX_NODES) : node_count_r;
  assign capture = (cmd.step == STEP_CAPTURE) && in_valid;
  assign load_ok = (in_node_index != '0) && (in_node_index <= IDX_W'(MAX_NODES));
  assign slot1   = EDGE_AW'(edge_total_r + EDGE_TOT_W'(1));
  assign slot2   = EDGE_AW'(edge_total_r + EDGE_TOT_W'(2));

  // Coordinate differences, magnitudes taken in the next register
  assign dx = {ca_r.x[COORD_W-1], ca_r.x} - {coord_q.x[COORD_W-1], coord_q.x};
  assign dy = {ca_r.y[COORD_W-1], ca_r.y} - {coord_q.y[COORD_W-1], coord_q.y};

  // Saturating relaxation sum
  assign sum_w = {1'b0, du_r} + (DIST_W+1)'(w_r);
  assign sum   = sum_w[DIST_W] ? DIST_MAX : sum_w[DIST_W-1:0];
  assign relax = (cmd.step == STEP_S_CMP) && (node_q.cost > sum);
  assign push  = relax && !node_q.mark && (qc_r < QCNT_W'(MAX_NODES));

  assign out_free = !out_valid_r || out_ready;
  assign out_load = (cmd.step == STEP_EMIT) && out_free;

  esp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.step == STEP_E_ROOT_GO),
    .radicand (SQ_IN_W'(sqx_r) + SQ_IN_W'(sqy_r)),
    .busy     (root_busy),
    .done     (root_done),
    .root     (root)
  );

  // Memory port selection per step
  always_comb begin
    coord_we = capture && (in_operation == OP_LOAD_NODE) && load_ok;
    coord_wa = node_addr(in_node_index);
    coord_wd = '{x: in_coord_x, y: in_coord_y};
    coord_ra = (cmd.step == STEP_E_RDB) ? node_addr(b_r) : node_addr(a_r);
    head_we  = 1'b0;
    head_wa  = clr_cnt_r;
    head_wd  = '0;
    head_ra  = node_addr(a_r);
    edge_we  = 1'b0;
    edge_wa  = slot1;
    edge_wd  = '{tgt: node_addr(b_r), wt: root, nxt: ha_r};
    edge_ra  = e_r;
    node_we  = 1'b0;
    node_wa  = clr_cnt_r;
    node_wd  = '{mark: 1'b0, cost: DIST_START};
    node_ra  = node_addr(t_r);
    queue_we = 1'b0;
    queue_wa = NODE_AW'(qh_r + qc_r[NODE_AW-1:0]);
    queue_wd = v_r;
    queue_ra = qh_r;
    case (cmd.step)
      STEP_CLEAR: head_we = 1'b1;
      STEP_E_HB:  head_ra = node_addr(b_r);
      STEP_E_LK1: begin
        edge_we = 1'b1;
        head_we = 1'b1;
        head_wa = node_addr(a_r);
        head_wd = slot1;
      end
      STEP_E_LK2: begin
        edge_we = 1'b1;
        edge_wa = slot2;
        edge_wd = '{tgt: node_addr(a_r), wt: root, nxt: (a_r == b_r) ? slot1 : hb_r};
        head_we = 1'b1;
        head_wa = node_addr(b_r);
        head_wd = slot2;
      end
      STEP_S_INIT: node_we = 1'b1;
      STEP_S_SEED: begin
        node_we  = 1'b1;
        node_wa  = node_addr(s_r);
        node_wd  = '{mark: 1'b1, cost: '0};
        queue_we = 1'b1;
        queue_wa = '0;
        queue_wd = node_addr(s_r);
      end
      STEP_S_U: node_ra = queue_q;
      STEP_S_UD: begin
        node_we = 1'b1;
        node_wa = u_r;
        node_wd = '{mark: 1'b0, cost: node_q.cost};
        head_ra = u_r;
      end
      STEP_S_ED: node_ra = edge_q.tgt;
      STEP_S_CMP: begin
        node_we  = relax;
        node_wa  = v_r;
        node_wd  = '{mark: node_q.mark | push, cost: sum};
        queue_we = push;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (coord_we) coord_mem[coord_wa] <= coord_wd;
    coord_q <= coord_mem[coord_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    edge_q <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_q <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_q <= queue_mem[queue_ra];
  end

  // Control registers: node count, edge total, sweep counter, queue pointers, output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= IDX_W'(1);
      edge_total_r <= '0;
      clr_cnt_r    <= '0;
      qh_r         <= '0;
      qc_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) node_count_r <= cfg_wr_data;
      if (cmd.step == STEP_CLEAR) edge_total_r <= '0;
      if (cmd.step == STEP_E_LK2) edge_total_r <= edge_total_r + EDGE_TOT_W'(2);
      if ((cmd.step == STEP_CLEAR) || (cmd.step == STEP_S_INIT)) clr_cnt_r <= clr_cnt_r + 1'b1;
      case (cmd.step)
        STEP_S_SEED: begin
          qh_r <= '0;
          qc_r <= QCNT_W'(1);
        end
        STEP_S_UD: begin
          qh_r <= qh_r + 1'b1;
          qc_r <= qc_r - 1'b1;
        end
        STEP_S_CMP: if (push) qc_r <= qc_r + 1'b1;
        default: ;
      endcase
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (capture) begin
      op_r <= op_t'(in_operation);
      a_r  <= in_edge_from;
      b_r  <= in_edge_to;
      s_r  <= in_source_node;
      t_r  <= in_target_node;
    end
    if (cmd.step == STEP_E_RDB) ca_r <= coord_q;
    if (cmd.step == STEP_E_DIF) begin
      ux_r <= dx[COORD_W] ? COORD_W'(~dx + 1'b1) : dx[COORD_W-1:0];
      uy_r <= dy[COORD_W] ? COORD_W'(~dy + 1'b1) : dy[COORD_W-1:0];
    end
    if (cmd.step == STEP_E_SQX) sqx_r <= ux_r * ux_r;
    if (cmd.step == STEP_E_SQY) sqy_r <= uy_r * uy_r;
    if (cmd.step == STEP_E_HB) ha_r <= head_q;
    if (cmd.step == STEP_E_HL) hb_r <= head_q;
    if (cmd.step == STEP_S_U) u_r <= queue_q;
    if (cmd.step == STEP_S_UD) du_r <= node_q.cost;
    if (cmd.step == STEP_S_HD) e_r <= head_q;
    if (cmd.step == STEP_S_ED) begin
      v_r  <= edge_q.tgt;
      w_r  <= edge_q.wt;
      nx_r <= edge_q.nxt;
    end
    if (cmd.step == STEP_S_CMP) e_r <= nx_r;
    if (cmd.step == STEP_E_CHK) begin
      res_dist_r    <= '0;
      res_reached_r <= 1'b0;
      res_ovf_r     <= status.ep_ok && status.edge_full;
    end
    if (cmd.step == STEP_S_TD) begin
      res_dist_r    <= ((t_r != '0) && (t_r <= n_use)) ? node_q.cost : DIST_START;
      res_reached_r <= ((t_r != '0) && (t_r <= n_use)) && (node_q.cost < DIST_START);
      res_ovf_r     <= 1'b0;
    end
    if (out_load) begin
      out_dist_r    <= res_dist_r;
      out_reached_r <= res_reached_r;
      out_ovf_r     <= res_ovf_r;
    end
  end

  // Status to the controller
  always_comb begin
    status.op        = op_r;
    status.ep_ok     = (a_r != '0) && (a_r <= n_use) && (b_r != '0) && (b_r <= n_use);
    status.edge_full = ((EDGE_TOT_W+1)'(edge_total_r) + (EDGE_TOT_W+1)'(2)) >
                       (EDGE_TOT_W+1)'(MAX_EDGE_SLOTS - 1);
    status.src_ok    = (s_r != '0) && (s_r <= n_use);
    status.clr_last  = &clr_cnt_r;
    status.root_done = root_done;
    status.edge_nil  = (e_r == '0);
    status.q_empty   = (qc_r == '0);
    status.out_free  = out_free;
  end

  assign out_valid         = out_valid_r;
  assign out_distance      = out_dist_r;
  assign out_reached       = out_reached_r;
  assign out_edge_overflow = out_ovf_r;

  a_qc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qc_r <= QCNT_W'(MAX_NODES))
    else $error("work queue count above node capacity");
  a_edge_total: assert property (@(posedge clk) disable iff (!rst_n)
    (edge_total_r[0] == 1'b0) && (edge_total_r <= EDGE_TOT_W'(MAX_EDGE_SLOTS - 1)))
    else $error("edge total odd or beyond the store");
  a_root_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == STEP_E_ROOT_GO) |-> !root_busy)
    else $error("square root restarted while busy");
  a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_valid_r) |-> out_ready)
    else $error("result register overwritten before it was taken");

endmodule

>>> rtl/esp_ctrl.sv
// Controller state machine: sequences clearing sweeps, edge loads and SPFA solves.
// Depends on esp_pkg; drives the datapath by step commands.
`timescale 1ns / 1ps

module esp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_operation,
  output logic              in_ready,
  input  esp_pkg::status_t  status,
  output esp_pkg::cmd_t     cmd
);
  import esp_pkg::*;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:    if (status.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_operation))
            OP_LOAD_NODE: state_nxt = S_IDLE;
            OP_ADD_EDGE:  state_nxt = S_E_CHK;
            OP_SOLVE:     state_nxt = S_S_INIT;
            OP_CLEAR:     state_nxt = S_CLR;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_E_CHK:  state_nxt = (status.ep_ok && !status.edge_full) ? S_E_RDA : S_EMIT;
      S_E_RDA:  state_nxt = S_E_RDB;
      S_E_RDB:  state_nxt = S_E_DIF;
      S_E_DIF:  state_nxt = S_E_SQX;
      S_E_SQX:  state_nxt = S_E_SQY;
      S_E_SQY:  state_nxt = S_E_RT0;
      S_E_RT0:  state_nxt = S_E_ROOT;
      S_E_ROOT: if (status.root_done) state_nxt = S_E_HA;
      S_E_HA:   state_nxt = S_E_HB;
      S_E_HB:   state_nxt = S_E_HL;
      S_E_HL:   state_nxt = S_E_LK1;
      S_E_LK1:  state_nxt = S_E_LK2;
      S_E_LK2:  state_nxt = S_EMIT;
      S_S_INIT: if (status.clr_last) state_nxt = status.src_ok ? S_S_SEED : S_S_TGT;
      S_S_SEED: state_nxt = S_S_POP;
      S_S_POP:  state_nxt = status.q_empty ? S_S_TGT : S_S_U;
      S_S_U:    state_nxt = S_S_UD;
      S_S_UD:   state_nxt = S_S_HD;
      S_S_HD:   state_nxt = S_S_EDGE;
      S_S_EDGE: state_nxt = status.edge_nil ? S_S_POP : S_S_ED;
      S_S_ED:   state_nxt = S_S_CMP;
      S_S_CMP:  state_nxt = S_S_EDGE;
      S_S_TGT:  state_nxt = S_S_TD;
      S_S_TD:   state_nxt = S_EMIT;
      S_EMIT:   if (status.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Step commands
  always_comb begin
    in_ready = 1'b0;
    cmd.step = STEP_NOP;
    case (state_r)
      S_CLR:    cmd.step = STEP_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.step = STEP_CAPTURE;
      end
      S_E_CHK:  cmd.step = STEP_E_CHK;
      S_E_RDA:  cmd.step = STEP_E_RDA;
      S_E_RDB:  cmd.step = STEP_E_RDB;
      S_E_DIF:  cmd.step = STEP_E_DIF;
      S_E_SQX:  cmd.step = STEP_E_SQX;
      S_E_SQY:  cmd.step = STEP_E_SQY;
      S_E_RT0:  cmd.step = STEP_E_ROOT_GO;
      S_E_HA:   cmd.step = STEP_E_HA;
      S_E_HB:   cmd.step = STEP_E_HB;
      S_E_HL:   cmd.step = STEP_E_HL;
      S_E_LK1:  cmd.step = STEP_E_LK1;
      S_E_LK2:  cmd.step = STEP_E_LK2;
      S_S_INIT: cmd.step = STEP_S_INIT;
      S_S_SEED: cmd.step = STEP_S_SEED;
      S_S_POP:  cmd.step = STEP_S_POP;
      S_S_U:    cmd.step = STEP_S_U;
      S_S_UD:   cmd.step = STEP_S_UD;
      S_S_HD:   cmd.step = STEP_S_HD;
      S_S_EDGE: cmd.step = STEP_S_EDGE;
      S_S_ED:   cmd.step = STEP_S_ED;
      S_S_CMP:  cmd.step = STEP_S_CMP;
      S_S_TGT:  cmd.step = STEP_S_TGT;
      S_S_TD:   cmd.step = STEP_S_TD;
      S_EMIT:   cmd.step = STEP_EMIT;
      default:  cmd.step = STEP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_EMIT))
    else $error("result stage entered straight from an accepted request");
  a_clr_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && !status.clr_last) |=> (state_r == S_CLR))
    else $error("clearing sweep left early");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !status.out_free) |=> (state_r == S_EMIT))
    else $error("result dropped while output register full");

endmodule

>>> rtl/euclidean_graph_shortest_path_unit.sv
// Top level of the Euclidean shortest path unit (SPFA over stored adjacency lists).
// Depends on esp_pkg, esp_ctrl and esp_dp.
//
//   port group  | handshake          | contents
//   in_*        | in_valid/in_ready  | operation, node_index, coords, edge ends, source/target
//   out_*       | out_valid/out_ready| distance, reached, edge_overflow
//   cfg_*       | cfg_wr_en          | node_count
//
// Load node is written straight from the idle state. Add edge waits on the 33-step
// square root. Clear edges sweeps the list heads. Solve sweeps the distance store,
// then works through each queue pop and each adjacency entry walked.
// After reset a sweep clears the list heads; no request is taken meanwhile.
// A finished result waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps

module euclidean_graph_shortest_path_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_operation,
  input  logic [esp_pkg::IDX_W-1:0]          in_node_index,
  input  logic signed [esp_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [esp_pkg::COORD_W-1:0] in_coord_y,
  input  logic [esp_pkg::IDX_W-1:0]          in_edge_from,
  input  logic [esp_pkg::IDX_W-1:0]          in_edge_to,
  input  logic [esp_pkg::IDX_W-1:0]          in_source_node,
  input  logic [esp_pkg::IDX_W-1:0]          in_target_node,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [esp_pkg::DIST_W-1:0]         out_distance,
  output logic                               out_reached,
  output logic                               out_edge_overflow,
  input  logic                               cfg_wr_en,
  input  logic [esp_pkg::IDX_W-1:0]          cfg_wr_data
);
  import esp_pkg::*;

  cmd_t    cmd;
  status_t status;

  esp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd)
  );

  esp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_valid          (in_valid),
    .in_operation      (in_operation),
    .in_node_index     (in_node_index),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_edge_from      (in_edge_from),
    .in_edge_to        (in_edge_to),
    .in_source_node    (in_source_node),
    .in_target_node    (in_target_node),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_distance      (out_distance),
    .out_reached       (out_reached),
    .out_edge_overflow (out_edge_overflow),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

endmodule
